// ===== sv/utbp_pkg.sv =====
// Shared types, character codes and sizing constants of the request-target byte parser.
`default_nettype none

package utbp_pkg;

	// Depth of the queue between the classifier and the state engine
	localparam int QUEUE_DEPTH = 2;

	// Result status codes
	localparam logic [1:0] STATUS_RUN  = 2'd0;
	localparam logic [1:0] STATUS_DONE = 2'd1;
	localparam logic [1:0] STATUS_ERR  = 2'd2;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Byte class as seen by the state engine
	typedef enum logic [2:0] {
		CL_OK,     // pchar or '/'
		CL_SPACE,
		CL_PCT,
		CL_HASH,
		CL_QMARK,
		CL_BAD
	} cls_t;

	// Classified item handed from front to back
	typedef struct packed {
		cls_t        cls;
		logic        hex;
		logic        first;
		logic [15:0] start;
	} item_t;

endpackage

`default_nettype wire

// ===== sv/utbp_ifs.sv =====
// Valid/ready channel interfaces for input bytes and parse results.
`default_nettype none

interface utbp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_value;
	logic        first_byte;
	logic [15:0] start_pos;

	modport source (output valid, output byte_value, output first_byte, output start_pos,
		input ready);
	modport sink (input valid, input byte_value, input first_byte, input start_pos,
		output ready);
endinterface

interface utbp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] position;
	logic [15:0] path_length;
	logic        query_seen;
	logic [15:0] query_begin;
	logic [15:0] query_length;
	logic        fragment_seen;
	logic [15:0] fragment_begin;
	logic [15:0] fragment_length;

	modport source (output valid, output status, output position, output path_length,
		output query_seen, output query_begin, output query_length,
		output fragment_seen, output fragment_begin, output fragment_length,
		input ready);
	modport sink (input valid, input status, input position, input path_length,
		input query_seen, input query_begin, input query_length,
		input fragment_seen, input fragment_begin, input fragment_length,
		output ready);
endinterface

`default_nettype wire

// ===== sv/utbp_front.sv =====
// Front stage: accepts input bytes, classifies them and registers the result.
`default_nettype none

module utbp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	utbp_in_if.sink             in_ch,
	output utbp_pkg::item_t     push_item,
	output logic                push_valid,
	input  wire logic           push_ready
);

	logic            valid_s1;
	utbp_pkg::item_t item_s1;
	utbp_pkg::item_t item_d;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	// pchar per RFC 3986, plus '/'
	function automatic logic is_path_char(input logic [7:0] c);
		logic ok;
		ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A);
		case (c)
			8'h2D, 8'h2E, 8'h5F, utbp_pkg::CH_TILDE,
			8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
			8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,
			8'h3A, utbp_pkg::CH_AT, utbp_pkg::CH_SLASH: ok = 1'b1;
			default: ;
		endcase
		return ok;
	endfunction

	function automatic utbp_pkg::cls_t classify(input logic [7:0] c);
		utbp_pkg::cls_t k;
		case (c)
			utbp_pkg::CH_SPACE: k = utbp_pkg::CL_SPACE;
			utbp_pkg::CH_PCT:   k = utbp_pkg::CL_PCT;
			utbp_pkg::CH_HASH:  k = utbp_pkg::CL_HASH;
			utbp_pkg::CH_QMARK: k = utbp_pkg::CL_QMARK;
			default:            k = is_path_char(c) ? utbp_pkg::CL_OK : utbp_pkg::CL_BAD;
		endcase
		return k;
	endfunction

	// Classification of the incoming byte
	always_comb begin
		item_d.cls   = classify(in_ch.byte_value);
		item_d.hex   = is_hex(in_ch.byte_value);
		item_d.first = in_ch.first_byte;
		item_d.start = in_ch.start_pos;
	end

	// Stage register; refills in the cycle it drains
	assign in_ch.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

`default_nettype wire

// ===== sv/utbp_queue.sv =====
// Small FIFO of classified items between the front and the back.
`default_nettype none

module utbp_queue #(
	parameter int DEPTH = utbp_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire utbp_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output utbp_pkg::item_t      pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	utbp_pkg::item_t  entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entries_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/utbp_back.sv =====
// Back stage: parser state engine; its state registers are the result payload.
`default_nettype none

module utbp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire utbp_pkg::item_t pop_item,
	utbp_out_if.source           out_ch
);

	typedef enum logic [2:0] {
		M_PATH  = 3'd0,
		M_QUERY = 3'd1,
		M_FRAG  = 3'd2,
		M_ESC   = 3'd3,
		M_ERR   = 3'd4
	} mode_t;

	mode_t       mode_q;
	logic [1:0]  esc_ret_q;
	logic        hex_one_q;
	logic        done_q;
	logic [15:0] cursor_q;
	logic [15:0] path_begin_q;
	logic [15:0] path_len_q;
	logic        query_seen_q;
	logic [15:0] query_begin_q;
	logic [15:0] query_len_q;
	logic        frag_seen_q;
	logic [15:0] frag_begin_q;
	logic [15:0] frag_len_q;
	logic        out_valid_q;

	mode_t       m;
	logic [1:0]  er;
	logic        h1;
	logic        dn;
	logic [15:0] cur;
	logic [15:0] pb;
	logic [15:0] pl;
	logic        qs;
	logic [15:0] qb;
	logic [15:0] ql;
	logic        fs;
	logic [15:0] fb;
	logic [15:0] fl;
	logic        at_top;
	logic        pop;

	// A new item is taken when the result register is free or being drained
	assign pop_ready = !out_valid_q || out_ch.ready;
	assign pop       = pop_valid && pop_ready;

	// Next state for the item at the head of the queue
	always_comb begin
		if (pop_item.first) begin
			m   = M_PATH;
			er  = 2'(M_PATH);
			h1  = 1'b0;
			dn  = 1'b0;
			cur = pop_item.start;
			pb  = pop_item.start;
			pl  = '0;
			qs  = 1'b0;
			qb  = '0;
			ql  = '0;
			fs  = 1'b0;
			fb  = '0;
			fl  = '0;
		end else begin
			m   = mode_q;
			er  = esc_ret_q;
			h1  = hex_one_q;
			dn  = done_q;
			cur = cursor_q;
			pb  = path_begin_q;
			pl  = path_len_q;
			qs  = query_seen_q;
			qb  = query_begin_q;
			ql  = query_len_q;
			fs  = frag_seen_q;
			fb  = frag_begin_q;
			fl  = frag_len_q;
		end
		at_top = (cur == 16'hFFFF);

		if (!dn && m != M_ERR) begin
			if (m == M_ESC) begin
				// hex digit of an escape; second digit returns to the saved mode
				if (!pop_item.hex || at_top) begin
					m = M_ERR;
				end else begin
					cur = cur + 16'd1;
					if (h1) begin
						m = mode_t'({1'b0, er});
					end else begin
						h1 = 1'b1;
					end
				end
			end else if (pop_item.cls == utbp_pkg::CL_SPACE) begin
				// end of target: close the open part
				case (m)
					M_PATH:  pl = cur - pb;
					M_QUERY: ql = cur - qb;
					default: fl = cur - fb;
				endcase
				dn = 1'b1;
			end else if (at_top) begin
				m = M_ERR;
			end else begin
				case (pop_item.cls)
					utbp_pkg::CL_PCT: begin
						er  = m[1:0];
						h1  = 1'b0;
						cur = cur + 16'd1;
						m   = M_ESC;
					end
					utbp_pkg::CL_HASH: begin
						if (m == M_FRAG) begin
							m = M_ERR;
						end else begin
							if (m == M_PATH) begin
								pl = cur - pb;
							end else begin
								ql = cur - qb;
							end
							cur = cur + 16'd1;
							fs  = 1'b1;
							fb  = cur;
							fl  = '0;
							m   = M_FRAG;
						end
					end
					utbp_pkg::CL_QMARK: begin
						if (m == M_PATH) begin
							pl  = cur - pb;
							cur = cur + 16'd1;
							qs  = 1'b1;
							qb  = cur;
							ql  = '0;
							m   = M_QUERY;
						end else begin
							cur = cur + 16'd1;
						end
					end
					utbp_pkg::CL_OK: begin
						cur = cur + 16'd1;
					end
					default: begin
						m = M_ERR;
					end
				endcase
			end
		end
	end

	// Parser state, which doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_PATH;
			esc_ret_q     <= 2'(M_PATH);
			hex_one_q     <= 1'b0;
			done_q        <= 1'b0;
			cursor_q      <= '0;
			path_begin_q  <= '0;
			path_len_q    <= '0;
			query_seen_q  <= 1'b0;
			query_begin_q <= '0;
			query_len_q   <= '0;
			frag_seen_q   <= 1'b0;
			frag_begin_q  <= '0;
			frag_len_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				mode_q        <= m;
				esc_ret_q     <= er;
				hex_one_q     <= h1;
				done_q        <= dn;
				cursor_q      <= cur;
				path_begin_q  <= pb;
				path_len_q    <= pl;
				query_seen_q  <= qs;
				query_begin_q <= qb;
				query_len_q   <= ql;
				frag_seen_q   <= fs;
				frag_begin_q  <= fb;
				frag_len_q    <= fl;
				out_valid_q   <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = (mode_q == M_ERR) ? utbp_pkg::STATUS_ERR :
		(done_q ? utbp_pkg::STATUS_DONE : utbp_pkg::STATUS_RUN);
	assign out_ch.position        = cursor_q;
	assign out_ch.path_length     = path_len_q;
	assign out_ch.query_seen      = query_seen_q;
	assign out_ch.query_begin     = query_begin_q;
	assign out_ch.query_length    = query_len_q;
	assign out_ch.fragment_seen   = frag_seen_q;
	assign out_ch.fragment_begin  = frag_begin_q;
	assign out_ch.fragment_length = frag_len_q;

`ifndef SYNTHESIS
	// state moves only when an item is taken
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(cursor_q) && $stable(mode_q) && $stable(done_q))
		else $error("parser state changed without an item");

	// a finished parse ignores bytes until a restart
	a_finished_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !pop_item.first && (done_q || mode_q == M_ERR) |=> $stable(cursor_q))
		else $error("finished parse advanced");

	// an escape never coexists with completion
	a_esc_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_ESC |-> !done_q)
		else $error("escape mode with completion set");

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !pop)
		else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== sv/uri_target_byte_parser_unit.sv =====
// Top level of the request-target byte parser: front classifier, queue, state engine.
`default_nettype none

// Takes one request-target byte per item and returns one result item per byte with the
// running parse status, cursor and the begin and length of path, query and fragment.
// A byte flagged first_byte restarts the parse at start_pos. Sustained rate is one item
// per clock cycle in both directions while the result channel is not stalled; that rate is
// set by the state engine, which updates all parser state for each byte at once. From
// input accept to result valid an item passes the classifier register, then a queue
// entry and then the state register, which is also the result register. QUEUE_DEPTH
// sizes the queue between classifier and state engine.
module uri_target_byte_parser_unit #(
	parameter int QUEUE_DEPTH = utbp_pkg::QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	utbp_in_if.sink     in_ch,
	utbp_out_if.source  out_ch
);

	utbp_pkg::item_t push_item;
	logic            push_valid;
	logic            push_ready;
	utbp_pkg::item_t pop_item;
	logic            pop_valid;
	logic            pop_ready;

	utbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	utbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	utbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire
